// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros, clocked on i_clk and off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/stie_pkg.sv =====
// ----------------------------------------------------------------------------
// stie_pkg
// types and constants of the session table with idle expiry
// ----------------------------------------------------------------------------
package stie_pkg;

    localparam int unsigned SESSION_SLOTS_DEF = 4;
    localparam int unsigned TIME_BITS_DEF     = 48;

    localparam int unsigned NOW_W      = 48;
    localparam int unsigned TOKEN_W    = 256;
    localparam int unsigned TIMEOUT_W  = 32;
    localparam int unsigned SLOT_IDX_W = 2;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd43200000;

    typedef enum logic [2:0] {
        OP_INSERT       = 3'd0,
        OP_LOOKUP       = 3'd1,
        OP_REMOVE       = 3'd2,
        OP_CLEAR_ALL    = 3'd3,
        OP_CLEAR_OTHERS = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [NOW_W-1:0] now_ms;
        logic [63:0]      token_word0;
        logic [63:0]      token_word1;
        logic [63:0]      token_word2;
        logic [63:0]      token_word3;
    } t_in_beat;

    typedef struct packed {
        logic                  found;
        logic [SLOT_IDX_W-1:0] slot_index;
    } t_out_beat;

endpackage

// ===== hw/rtl/session_table_idle_expiry.sv =====
// ----------------------------------------------------------------------------
// session_table_idle_expiry
// small table of 256-bit session tokens with idle expiry and oldest-slot
// replacement, scanned one slot at a time
// ----------------------------------------------------------------------------
// One beat in, one beat out. The table is walked one slot at a time by a small
// sequencer around a single evaluation unit (token equality, age subtract and
// timeout compare, oldest-time compare). Each visited slot is first read from
// the slot memory and then evaluated; an item visits one slot at best and all
// SESSION_SLOTS slots at worst (four at four slots), while clear all and
// unknown opcodes skip the scan and go straight to the finish state.
// The input is stalled while an item is in work; a finished result sits in an
// output register, so the next item can be taken while that beat waits.
// Tokens and last-seen times live in a slot memory; only the per-slot valid
// bits are flip-flops, so reset needs no clearing pass. The idle timeout is
// to be written on the config channel while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module session_table_idle_expiry #(
    parameter int unsigned SESSION_SLOTS = stie_pkg::SESSION_SLOTS_DEF,
    parameter int unsigned TIME_BITS     = stie_pkg::TIME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [stie_pkg::TIMEOUT_W-1:0]  i_cfg_data,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  stie_pkg::t_in_beat              i_in_beat,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output stie_pkg::t_out_beat             o_out_beat
);

    import stie_pkg::*;

    localparam int unsigned IDX_W = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SESSION_SLOTS - 1);

    // control state
    t_state                     r_state, n_state;
    logic [IDX_W-1:0]           r_idx, n_idx;
    logic [SESSION_SLOTS-1:0]   r_valid, n_valid;
    logic                       r_out_valid, n_out_valid;
    logic [TIMEOUT_W-1:0]       r_timeout;

    // item context
    logic [2:0]                 r_op, n_op;
    logic [TIME_BITS-1:0]       r_now, n_now;
    logic [TOKEN_W-1:0]         r_tok, n_tok;
    logic                       r_found, n_found;
    logic [IDX_W-1:0]           r_slot, n_slot;
    logic [TIME_BITS-1:0]       r_oldest, n_oldest;
    logic [IDX_W-1:0]           r_oldest_idx, n_oldest_idx;
    t_out_beat                  r_out_beat, n_out_beat;

    // slot memory
    logic [TOKEN_W-1:0]         r_tok_mem  [SESSION_SLOTS];
    logic [TIME_BITS-1:0]       r_time_mem [SESSION_SLOTS];
    logic [TOKEN_W-1:0]         r_rd_tok;
    logic [TIME_BITS-1:0]       r_rd_time;
    logic                       w_tok_we;
    logic                       w_time_we;
    logic [IDX_W-1:0]           w_addr;

    // evaluation unit
    logic                       w_in_take;
    logic                       w_out_take;
    logic                       w_out_free;
    logic [TIME_BITS+NOW_W-1:0] w_now_ext;
    logic [TIME_BITS-1:0]       w_age;
    logic                       w_expired;
    logic                       w_match;
    logic                       w_slot_valid;
    logic                       w_last;
    logic                       w_older;
    logic                       w_free;
    logic [IDX_W-1:0]           w_pick;
    logic                       w_eval_done;
    logic [IDX_W+SLOT_IDX_W-1:0] w_slot_ext;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    assign w_in_take  = i_in_valid && !o_in_stall;
    assign w_out_take = r_out_valid && !i_out_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // now_ms reduced (or widened) to the table's time width
    assign w_now_ext = {TIME_BITS'(0), i_in_beat.now_ms};

    // age wraps modulo 2^TIME_BITS
    assign w_age        = r_now - r_rd_time;
    assign w_expired    = w_age > TIME_BITS'(r_timeout);
    assign w_match      = (r_rd_tok == r_tok);
    assign w_slot_valid = r_valid[r_idx];
    assign w_last       = (r_idx == IDX_LAST);

    // insert: free or stale slot wins, else oldest time, lowest index on ties
    assign w_older = (r_rd_time < r_oldest);
    assign w_free  = !w_slot_valid || w_expired;
    assign w_pick  = (w_free || w_older) ? r_idx : r_oldest_idx;

    // slot index on the port is the slot number masked to two bits
    assign w_slot_ext = {SLOT_IDX_W'(0), r_slot};

    always_comb begin
        case (r_op)
            OP_INSERT:       w_eval_done = w_free || w_last;
            OP_LOOKUP:       w_eval_done = (w_slot_valid && !w_expired && w_match) || w_last;
            OP_REMOVE:       w_eval_done = (w_slot_valid && w_match) || w_last;
            OP_CLEAR_OTHERS: w_eval_done = w_last;
            default:         w_eval_done = 1'b1;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_take) begin
                    if (i_in_beat.opcode inside {OP_INSERT, OP_LOOKUP, OP_REMOVE,
                                                 OP_CLEAR_OTHERS}) begin
                        n_state = ST_READ;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                n_state = w_eval_done ? ST_FINISH : ST_READ;
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_idx         = r_idx;
        n_valid       = r_valid;
        n_op          = r_op;
        n_now         = r_now;
        n_tok         = r_tok;
        n_found       = r_found;
        n_slot        = r_slot;
        n_oldest      = r_oldest;
        n_oldest_idx  = r_oldest_idx;
        n_out_valid   = r_out_valid && !w_out_take;
        n_out_beat    = r_out_beat;
        w_tok_we      = 1'b0;
        w_time_we     = 1'b0;
        w_addr        = r_idx;

        case (r_state)
            ST_IDLE: begin
                if (w_in_take) begin
                    n_op          = i_in_beat.opcode;
                    n_now         = w_now_ext[TIME_BITS-1:0];
                    n_tok         = {i_in_beat.token_word3, i_in_beat.token_word2,
                                     i_in_beat.token_word1, i_in_beat.token_word0};
                    n_idx         = '0;
                    n_found       = 1'b0;
                    n_slot        = '0;
                    n_oldest      = '1;
                    n_oldest_idx  = '0;
                    if (i_in_beat.opcode == OP_CLEAR_ALL) begin
                        n_valid = '0;
                    end
                end
            end
            ST_EVAL: begin
                case (r_op)
                    OP_INSERT: begin
                        if (w_older) begin
                            n_oldest      = r_rd_time;
                            n_oldest_idx  = r_idx;
                        end
                        if (w_free || w_last) begin
                            w_addr          = w_pick;
                            w_tok_we        = 1'b1;
                            w_time_we       = 1'b1;
                            n_valid[w_pick] = 1'b1;
                            n_found         = 1'b1;
                            n_slot          = w_pick;
                        end
                    end
                    OP_LOOKUP: begin
                        if (w_slot_valid) begin
                            if (w_expired) begin
                                n_valid[r_idx] = 1'b0;
                            end else if (w_match) begin
                                w_time_we = 1'b1;
                                n_found   = 1'b1;
                                n_slot    = r_idx;
                            end
                        end
                    end
                    OP_REMOVE: begin
                        if (w_slot_valid && w_match) begin
                            n_valid[r_idx] = 1'b0;
                            n_found        = 1'b1;
                            n_slot         = r_idx;
                        end
                    end
                    OP_CLEAR_OTHERS: begin
                        if (w_slot_valid && !w_match) begin
                            n_valid[r_idx] = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
                if (!w_eval_done) begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_out_valid           = 1'b1;
                    n_out_beat.found      = r_found;
                    n_out_beat.slot_index = w_slot_ext[SLOT_IDX_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_timeout   <= TIMEOUT_RESET;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_op          <= n_op;
        r_now         <= n_now;
        r_tok         <= n_tok;
        r_found       <= n_found;
        r_slot        <= n_slot;
        r_oldest      <= n_oldest;
        r_oldest_idx  <= n_oldest_idx;
        r_out_beat    <= n_out_beat;
    end

    // slot memory: one write port, one registered read port at the scan index
    always_ff @(posedge i_clk) begin
        if (w_tok_we) begin
            r_tok_mem[w_addr] <= r_tok;
        end
        if (w_time_we) begin
            r_time_mem[w_addr] <= r_now;
        end
        r_rd_tok  <= r_tok_mem[r_idx];
        r_rd_time <= r_time_mem[r_idx];
    end

`include "assert_macros.svh"

    `ASSERT_NXT(a_accept_starts, w_in_take,
        r_state == ST_READ || r_state == ST_FINISH,
        "item accepted but sequencer did not start")
    `ASSERT_IMP(a_miss_slot_zero, r_out_valid && !r_out_beat.found,
        r_out_beat.slot_index == SLOT_IDX_W'(0),
        "miss reported with nonzero slot")
    `ASSERT_NXT(a_finish_loads, r_state == ST_FINISH && w_out_free,
        r_out_valid && r_state == ST_IDLE,
        "finished item not presented")
    `ASSERT_IMP(a_eval_scan_range, r_state == ST_EVAL, r_idx <= IDX_LAST,
        "scan index past last slot")

endmodule
